// File: src/bhm_pkg.sv
`timescale 1ns / 1ps
package bhm_pkg;

    localparam int BYTE_W    = 8;
    localparam int BIN_COUNT = 256;
    localparam int OUT_W     = 16;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;

    // classified request, front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              is_lower_a;
        logic              is_upper;
        logic              block_end;
    } item_t;

    // block summary, back to output register
    typedef struct packed {
        logic [OUT_W-1:0]  lower_a_count;
        logic [OUT_W-1:0]  upper_count;
        logic [BYTE_W-1:0] mode_byte;
        logic [OUT_W-1:0]  mode_count;
    } result_t;

endpackage

// File: src/bhm_ram.sv
`timescale 1ns / 1ps
module bhm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/bhm_front.sv
`timescale 1ns / 1ps
module bhm_front (
    input  logic                        clk,
    input  logic                        resetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bhm_pkg::BYTE_W-1:0]  in_data_byte,
    input  logic                        in_block_end,
    output logic                        item_valid,
    input  logic                        item_ready,
    output bhm_pkg::item_t              item
);

    bhm_pkg::item_t                 entry_reg [bhm_pkg::Q_DEPTH];
    logic [bhm_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [bhm_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [bhm_pkg::Q_CNT_W-1:0]    count_reg, count_next;
    bhm_pkg::item_t                 classified;
    logic                           push, pop;

    // classify the byte on the way in
    always_comb begin
        classified.data_byte  = in_data_byte;
        classified.is_lower_a = (in_data_byte == bhm_pkg::CHAR_LOWER_A);
        classified.is_upper   = (in_data_byte >= bhm_pkg::CHAR_UPPER_A) &&
                                (in_data_byte <= bhm_pkg::CHAR_UPPER_Z);
        classified.block_end  = in_block_end;
    end

    assign in_ready   = (count_reg != bhm_pkg::Q_CNT_W'(bhm_pkg::Q_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = entry_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = item_valid && item_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == bhm_pkg::Q_PTR_W'(bhm_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == bhm_pkg::Q_PTR_W'(bhm_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk) begin
        if (!resetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// File: src/bhm_back.sv
`timescale 1ns / 1ps
module bhm_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              clk,
    input  logic              resetn,
    input  logic              item_valid,
    output logic              item_ready,
    input  bhm_pkg::item_t    item,
    output logic              res_valid,
    input  logic              res_ready,
    output bhm_pkg::result_t  res
);

    localparam int BIN_W = $clog2(bhm_pkg::BIN_COUNT);

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
    endfunction

    // per-bin valid: a bin not touched in this block reads as zero
    logic [bhm_pkg::BIN_COUNT-1:0] bin_valid_reg;

    // bin update stage
    logic                          stg_valid_reg;
    bhm_pkg::item_t                stg_item_reg;
    logic                          stg_hit_reg;

    // write forwarded from the update that coincided with this stage's read
    logic                          fwd_en_reg;
    logic [BIN_W-1:0]              fwd_addr_reg;
    logic [COUNT_WIDTH-1:0]        fwd_data_reg;

    logic [COUNT_WIDTH-1:0]        a_tally_reg, a_tally_next;
    logic [COUNT_WIDTH-1:0]        upper_tally_reg, upper_tally_next;
    logic [bhm_pkg::BYTE_W-1:0]    best_byte_reg, best_byte_next;
    logic [COUNT_WIDTH-1:0]        best_tally_reg, best_tally_next;

    logic [COUNT_WIDTH-1:0]        ram_rd_data;
    logic [COUNT_WIDTH-1:0]        old_cnt, new_cnt;
    logic                          stg_fire, stg_last, pop, wr_en, clear_block;
    logic [BIN_W-1:0]              stg_addr, head_addr;

    assign stg_addr    = BIN_W'(stg_item_reg.data_byte);
    assign head_addr   = BIN_W'(item.data_byte);
    assign stg_last    = stg_item_reg.block_end;
    assign stg_fire    = stg_valid_reg && (!stg_last || res_ready);
    assign item_ready  = !stg_valid_reg || stg_fire;
    assign pop         = item_valid && item_ready;
    assign clear_block = stg_fire && stg_last;
    assign wr_en       = stg_fire && !stg_last;

    bhm_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (bhm_pkg::BIN_COUNT)
    ) u_bins (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (stg_addr),
        .wr_data (new_cnt),
        .rd_en   (pop),
        .rd_addr (head_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        if (fwd_en_reg && (fwd_addr_reg == stg_addr)) begin
            old_cnt = fwd_data_reg;
        end else if (stg_hit_reg) begin
            old_cnt = ram_rd_data;
        end else begin
            old_cnt = '0;
        end
        new_cnt = sat_inc(old_cnt);

        a_tally_next     = stg_item_reg.is_lower_a ? sat_inc(a_tally_reg) : a_tally_reg;
        upper_tally_next = stg_item_reg.is_upper ? sat_inc(upper_tally_reg) : upper_tally_reg;
        best_byte_next   = best_byte_reg;
        best_tally_next  = best_tally_reg;
        if ((new_cnt > best_tally_reg) ||
            ((new_cnt == best_tally_reg) && (stg_item_reg.data_byte < best_byte_reg))) begin
            best_byte_next  = stg_item_reg.data_byte;
            best_tally_next = new_cnt;
        end
    end

    // counts leave as their low 16 bits
    always_comb begin
        logic [COUNT_WIDTH+bhm_pkg::OUT_W-1:0] ext_a, ext_u, ext_m;
        ext_a = {{bhm_pkg::OUT_W{1'b0}}, a_tally_next};
        ext_u = {{bhm_pkg::OUT_W{1'b0}}, upper_tally_next};
        ext_m = {{bhm_pkg::OUT_W{1'b0}}, best_tally_next};
        res.lower_a_count = ext_a[bhm_pkg::OUT_W-1:0];
        res.upper_count   = ext_u[bhm_pkg::OUT_W-1:0];
        res.mode_byte     = best_byte_next;
        res.mode_count    = ext_m[bhm_pkg::OUT_W-1:0];
    end

    assign res_valid = stg_valid_reg && stg_last;

    always_ff @(posedge clk) begin
        if (!resetn) begin
            stg_valid_reg   <= 1'b0;
            fwd_en_reg      <= 1'b0;
            bin_valid_reg   <= '0;
            a_tally_reg     <= '0;
            upper_tally_reg <= '0;
            best_byte_reg   <= '0;
            best_tally_reg  <= '0;
        end else begin
            if (pop) begin
                stg_valid_reg <= 1'b1;
                // clear at the same edge wins over the sampled bit
                stg_hit_reg   <= bin_valid_reg[head_addr] && !clear_block;
                stg_item_reg  <= item;
                fwd_en_reg    <= wr_en;
                fwd_addr_reg  <= stg_addr;
                fwd_data_reg  <= new_cnt;
            end else if (stg_fire) begin
                stg_valid_reg <= 1'b0;
            end

            if (clear_block) begin
                bin_valid_reg   <= '0;
                a_tally_reg     <= '0;
                upper_tally_reg <= '0;
                best_byte_reg   <= '0;
                best_tally_reg  <= '0;
            end else if (wr_en) begin
                bin_valid_reg[stg_addr] <= 1'b1;
                a_tally_reg     <= a_tally_next;
                upper_tally_reg <= upper_tally_next;
                best_byte_reg   <= best_byte_next;
                best_tally_reg  <= best_tally_next;
            end
        end
    end

endmodule

// File: src/byte_histogram_mode_counter.sv
`timescale 1ns / 1ps
// Byte histogram with running mode. Bytes of a block arrive one per request on
// s_*, the last one flagged by s_block_end. The block counts bytes equal to 'a',
// uppercase letters 'A'..'Z', keeps a 256-bin histogram and tracks the most
// frequent byte (the smaller byte value wins a tie). Counters and bins saturate
// at 2^COUNT_WIDTH-1; each output count carries the low 16 bits. On the last
// byte one result request on m_* gives all four values, and the histogram and
// counters start over for the next block. Throughput is one byte per clock,
// sustained: the histogram sits in a 256-entry RAM with one read and one write
// port, read as a byte enters the bin update stage and written back as it
// leaves, with a forwarding register covering back-to-back hits on the same
// bin. Clearing is instant: each bin has a valid flop that the block end
// clears, so there is no clearing pass after reset or between blocks. After
// the final byte is accepted it passes through the input queue and the bin
// update stage, and the result is then loaded into the output register that
// drives m_valid. A two-entry queue separates the classifying front from the
// bin update, and the output register lets the next block stream in while a
// result waits on m_ready; the pipe stalls only when a second block end
// reaches the update stage before the previous result was taken.
module byte_histogram_mode_counter #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_data_byte,
    input  logic                        s_block_end,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [15:0]                 m_lower_a_count,
    output logic [15:0]                 m_upper_count,
    output logic [7:0]                  m_mode_byte,
    output logic [15:0]                 m_mode_count
);

    logic              item_valid, item_ready;
    bhm_pkg::item_t    item;
    logic              res_valid, res_ready;
    bhm_pkg::result_t  res;

    logic              out_valid_reg;
    bhm_pkg::result_t  out_reg;

    // front: accept and classify, queue toward the bin update
    bhm_front u_front (
        .clk          (aclk),
        .resetn       (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_data_byte (s_data_byte),
        .in_block_end (s_block_end),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item)
    );

    // back: histogram read-modify-write, tallies and mode
    bhm_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk        (aclk),
        .resetn     (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // result register: free, or being taken this cycle
    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_lower_a_count = out_reg.lower_a_count;
    assign m_upper_count   = out_reg.upper_count;
    assign m_mode_byte     = out_reg.mode_byte;
    assign m_mode_count    = out_reg.mode_count;

endmodule

// File: verif/byte_histogram_mode_checker.sv
`timescale 1ns / 1ps
module byte_histogram_mode_checker #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [7:0]        s_data_byte,
    input  logic              s_block_end,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [15:0]       m_lower_a_count,
    input  logic [15:0]       m_upper_count,
    input  logic [7:0]        m_mode_byte,
    input  logic [15:0]       m_mode_count,
    output int unsigned       fail_count,
    output int unsigned       pending_results,
    output int unsigned       summaries_checked
);

    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

    int unsigned       bin_tally [bhm_pkg::BIN_COUNT];
    int unsigned       a_total;
    int unsigned       upper_total;
    int unsigned       lead_tally;
    logic [7:0]        lead_byte;
    bhm_pkg::result_t  expected_summaries [$];
    int unsigned       mismatches = 0;
    int unsigned       matched = 0;

    assign fail_count        = mismatches;
    assign summaries_checked = matched;

    function automatic int unsigned sat_bump(input int unsigned v);
        return (v >= COUNT_MAX) ? v : v + 1;
    endfunction

    task automatic clear_block();
        foreach (bin_tally[i]) bin_tally[i] = 0;
        a_total     = 0;
        upper_total = 0;
        lead_tally  = 0;
        lead_byte   = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        int unsigned       c;
        bhm_pkg::result_t  summary;
        if (b == bhm_pkg::CHAR_LOWER_A)
            a_total = sat_bump(a_total);
        if (b >= bhm_pkg::CHAR_UPPER_A && b <= bhm_pkg::CHAR_UPPER_Z)
            upper_total = sat_bump(upper_total);
        c = sat_bump(bin_tally[b]);
        bin_tally[b] = c;
        // running mode, smaller byte wins a tie
        if (c > lead_tally || (c == lead_tally && b < lead_byte)) begin
            lead_tally = c;
            lead_byte  = b;
        end
        if (last) begin
            summary.lower_a_count = bhm_pkg::OUT_W'(a_total);
            summary.upper_count   = bhm_pkg::OUT_W'(upper_total);
            summary.mode_byte     = lead_byte;
            summary.mode_count    = bhm_pkg::OUT_W'(lead_tally);
            expected_summaries.push_back(summary);
            clear_block();
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic take_summary();
        bhm_pkg::result_t want;
        if (expected_summaries.size() == 0) begin
            $error("result with no block pending: a=%0d upper=%0d mode=%0d x%0d",
                   m_lower_a_count, m_upper_count, m_mode_byte, m_mode_count);
            mismatches++;
        end else begin
            want = expected_summaries.pop_front();
            check_field("lower_a_count", want.lower_a_count, m_lower_a_count);
            check_field("upper_count", want.upper_count, m_upper_count);
            check_field("mode_byte", 16'(want.mode_byte), 16'(m_mode_byte));
            check_field("mode_count", want.mode_count, m_mode_count);
            matched++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_block();
            expected_summaries.delete();
        end else begin
            if (m_valid && m_ready)
                take_summary();
            if (s_valid && s_ready)
                absorb_byte(s_data_byte, s_block_end);
        end
        pending_results <= expected_summaries.size();
    end

endmodule

// File: verif/byte_histogram_mode_counter_test.sv
`timescale 1ns / 1ps
module byte_histogram_mode_counter_test;

    localparam int COUNT_WIDTH   = 16;
    localparam int RANDOM_BYTES  = 1850;
    // longest quiet stretch: sender gap + receiver stall + pipe, with margin
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 10;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_block_end = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [15:0] m_lower_a_count;
    logic [15:0] m_upper_count;
    logic [7:0]  m_mode_byte;
    logic [15:0] m_mode_count;

    int unsigned fail_count;
    int unsigned pending_results;
    int unsigned summaries_checked;

    int unsigned burst_left   = 0;
    int unsigned bytes_sent   = 0;
    int unsigned random_bytes = 0;
    int unsigned ready_hold   = 0;
    int unsigned idle_cycles  = 0;

    byte_histogram_mode_counter #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_block_end    (s_block_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lower_a_count(m_lower_a_count),
        .m_upper_count  (m_upper_count),
        .m_mode_byte    (m_mode_byte),
        .m_mode_count   (m_mode_count)
    );

    // Prediction and comparison live in the checker; this module only
    // generates traffic and calls the verdict.
    byte_histogram_mode_checker #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) summary_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_block_end      (s_block_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_lower_a_count  (m_lower_a_count),
        .m_upper_count    (m_upper_count),
        .m_mode_byte      (m_mode_byte),
        .m_mode_count     (m_mode_count),
        .fail_count       (fail_count),
        .pending_results  (pending_results),
        .summaries_checked(summaries_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver back-pressure: picks a new behavior whenever the current one
    // runs out. Long free-flowing windows, per-cycle chatter, short stalls
    // and the occasional long stall that backs the pipe up into s_ready.
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    m_ready    <= 1'b1;
                    ready_hold <= $urandom_range(10, 200);
                end
                4, 5, 6: begin
                    m_ready    <= 1'($urandom_range(0, 1));
                    ready_hold <= 0;
                end
                7, 8: begin
                    m_ready    <= 1'b0;
                    ready_hold <= $urandom_range(1, 8);
                end
                default: begin
                    m_ready    <= 1'b0;
                    ready_hold <= $urandom_range(20, 60);
                end
            endcase
        end
    end

    // Watchdog: any accepted request on either side resets the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Watchdog: no request moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one byte and hold it until accepted. Traffic comes in bursts;
    // at the start of each burst there may be a gap with valid low. A quarter
    // of the bursts follow on with no gap at all.
    task automatic send_byte(input logic [7:0] value, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_data_byte <= value;
        s_block_end <= last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Hold off the sender until every block summary has come back.
    // The first edge lets the checker's count catch up with the last request.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    // One random block. Length is mostly short with a tail of longer blocks.
    // Content style: any byte, letter-heavy text around the counted ranges,
    // a small pool (builds high counts and ties), or two values (near ties).
    task automatic send_random_block();
        int unsigned len;
        int unsigned style;
        int unsigned k;
        logic [7:0]  pool [4];
        logic [7:0]  b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 16);
            7, 8:                len = $urandom_range(17, 64);
            default:             len = $urandom_range(65, 200);
        endcase
        style = $urandom_range(0, 3);
        foreach (pool[i]) pool[i] = 8'($urandom_range(0, 255));
        for (k = 0; k < len; k++) begin
            case (style)
                0: b = 8'($urandom_range(0, 255));
                1: begin
                    case ($urandom_range(0, 4))
                        0: b = bhm_pkg::CHAR_LOWER_A;
                        1: b = bhm_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 25));
                        2: b = bhm_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25));
                        3: begin
                            // just outside the counted ranges
                            case ($urandom_range(0, 3))
                                0: b = bhm_pkg::CHAR_UPPER_A - 8'd1;
                                1: b = bhm_pkg::CHAR_UPPER_Z + 8'd1;
                                2: b = bhm_pkg::CHAR_LOWER_A - 8'd1;
                                default: b = bhm_pkg::CHAR_LOWER_A + 8'd1;
                            endcase
                        end
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                end
                2: b = pool[2'($urandom_range(0, 3))];
                default: b = pool[2'($urandom_range(0, 1))];
            endcase
            send_byte(b, k == len - 1);
        end
        random_bytes += len;
    endtask

    initial begin
        int unsigned half_drained;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed ----
        // single-byte blocks: extremes of the byte and each counted class
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(bhm_pkg::CHAR_LOWER_A, 1'b1);
        send_byte(bhm_pkg::CHAR_UPPER_A, 1'b1);
        send_byte(bhm_pkg::CHAR_UPPER_Z, 1'b1);
        // neighbors of the counted ranges count nothing; four-way tie at 1
        send_byte(bhm_pkg::CHAR_UPPER_A - 8'd1, 1'b0);
        send_byte(bhm_pkg::CHAR_UPPER_Z + 8'd1, 1'b0);
        send_byte(bhm_pkg::CHAR_LOWER_A - 8'd1, 1'b0);
        send_byte(bhm_pkg::CHAR_LOWER_A + 8'd1, 1'b1);
        // later tie on a smaller byte takes over the mode
        send_byte(bhm_pkg::CHAR_UPPER_Z, 1'b0);
        send_byte(bhm_pkg::CHAR_UPPER_A, 1'b0);
        send_byte(bhm_pkg::CHAR_UPPER_Z, 1'b0);
        send_byte(bhm_pkg::CHAR_UPPER_A, 1'b1);
        // a strictly larger count wins regardless of value
        send_byte(8'h80, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h10, 1'b1);
        // high byte leads, low byte does not catch up
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        drain_results();

        // ---- random blocks ----
        half_drained = 0;
        while (random_bytes < RANDOM_BYTES) begin
            send_random_block();
            if (!half_drained && random_bytes >= RANDOM_BYTES / 2) begin
                drain_results();
                half_drained = 1;
            end
        end

        // ---- wind down ----
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d bytes, %0d block summaries checked: single-byte blocks,",
                 bytes_sent, summaries_checked);
        $display("range edges, tie breaks, random blocks under bursty input and stalls.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: byte_histogram_mode_counter.f
src/bhm_pkg.sv
src/bhm_ram.sv
src/bhm_front.sv
src/bhm_back.sv
src/byte_histogram_mode_counter.sv
verif/byte_histogram_mode_checker.sv
verif/byte_histogram_mode_counter_test.sv
